/* hdl/dq_pkg.sv */
// dq_pkg: shared widths, command codes and status codes for the deque.
// Used by dq_ram, dq_ctrl and double_ended_queue; depends on nothing.
`default_nettype none

package dq_pkg;

  // default number of ring entries
  localparam int DEPTH_DEF = 64;

  // field widths
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int STAT_W = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  // command codes
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_DUMP_FWD   = 3'd4;
  localparam cmd_t CMD_DUMP_REV   = 3'd5;

  // result status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

/* hdl/dq_ram.sv */
// dq_ram: ring storage for the deque, one write and one read port,
// read data registered. Depends on dq_pkg for the word width.
`default_nettype none

module dq_ram #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [dq_pkg::VAL_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [dq_pkg::VAL_W-1:0] rd_data
);
  import dq_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/dq_ctrl.sv */
// dq_ctrl: front index, entry count, command decode, dump sequencer and
// output register of the deque. Depends on dq_pkg; drives dq_ram.
`default_nettype none

module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire dq_pkg::cmd_t                  command,
  input  wire logic signed [dq_pkg::VAL_W-1:0] value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [dq_pkg::VAL_W-1:0]    value_res,
  output dq_pkg::status_t                    status,
  output logic                               last,
  // memory port
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output logic [dq_pkg::VAL_W-1:0]           wr_data,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr,
  input  wire logic [dq_pkg::VAL_W-1:0]      rd_data
);
  import dq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // (a + b) mod DEPTH with both operands below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  logic          state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic          dir_rev, dir_rev_next;
  logic          pend;        // read data waiting in the memory output
  logic          pend_last;
  logic          issue_last;
  logic          imm_load;
  status_t       imm_status;

  logic out_free, load_now, can_issue, acc;
  logic is_full, is_empty, dump_last;
  logic [AW-1:0] back_off, rev_off;

  // handshake and occupancy
  assign out_free  = !out_valid || !out_stall;
  assign load_now  = pend && out_free;
  assign can_issue = !pend || load_now;
  assign in_stall  = (state != ST_IDLE) || pend || !out_free;
  assign acc       = in_valid && !in_stall;

  assign is_full   = (count == DEPTH_C);
  assign is_empty  = (count == '0);
  assign back_off  = AW'(count - CW'(1));
  assign rev_off   = AW'(count - CW'(1) - CW'(idx));
  assign dump_last = ((CW'(idx) + CW'(1)) == count);
  assign wr_data   = value;

  // command decode and dump sequencing
  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    idx_next     = idx;
    dir_rev_next = dir_rev;
    wr_en        = 1'b0;
    wr_addr      = front;
    rd_en        = 1'b0;
    rd_addr      = front;
    issue_last   = 1'b1;
    imm_load     = 1'b0;
    imm_status   = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              imm_load = 1'b1;
              if (is_full) begin
                imm_status = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                if (command == CMD_PUSH_FRONT) begin
                  front_next = (front == '0) ? LAST_POS : front - AW'(1);
                  wr_addr    = front_next;
                end else begin
                  wr_addr = ring_add(front, AW'(count));
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (is_empty) begin
                imm_load   = 1'b1;
                imm_status = STAT_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - CW'(1);
                if (command == CMD_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = ring_add(front, AW'(1));
                end else begin
                  rd_addr = ring_add(front, back_off);
                end
              end
            end
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
              if (is_empty) begin
                imm_load   = 1'b1;
                imm_status = STAT_EMPTY;
              end else begin
                state_next   = ST_DUMP;
                idx_next     = '0;
                dir_rev_next = (command == CMD_DUMP_REV);
              end
            end
            default: begin
              // unused codes: no result, no change
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (can_issue) begin
          rd_en      = 1'b1;
          rd_addr    = dir_rev ? ring_add(front, rev_off) : ring_add(front, idx);
          issue_last = dump_last;
          idx_next   = idx + AW'(1);
          if (dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (rd_en) begin
        pend <= 1'b1;
      end else if (load_now) begin
        pend <= 1'b0;
      end
      if (load_now || imm_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer payload and output word
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    dir_rev <= dir_rev_next;
    if (rd_en) begin
      pend_last <= issue_last;
    end
    if (load_now) begin
      value_res <= rd_data;
      status    <= STAT_OK;
      last      <= pend_last;
    end else if (imm_load) begin
      value_res <= '0;
      status    <= imm_status;
      last      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/double_ended_queue.sv */
// double_ended_queue: deque of signed 32-bit words in a ring memory.
// Depends on dq_pkg, dq_ram and dq_ctrl.
//
// Usage:
//   Command channel (in_valid / in_stall, command, value): one command per
//   word. Result channel (out_valid / out_stall, value_res, status, last).
//   Push and pop give one result; a dump gives one result per stored entry
//   with last set on the final one. Errors (empty, full) give one result.
// Timing and flow:
//   Push and error results load the output register directly; pop data
//   passes the memory read register, then the output register. A dump of
//   N entries streams one word per cycle while out_stall is low. The next
//   command is taken once no dump is running, no read word waits in the
//   memory read register and the output register can load; the single
//   read port of the ring memory sets the dump rate.
// Reset:
//   rst (synchronous) empties the queue; memory contents are not cleared.
// Stall:
//   While out_stall holds a result word in place, in_stall stays high and
//   a dump pauses with the pending word kept in the memory read register.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire dq_pkg::cmd_t                    command,
  input  wire logic signed [dq_pkg::VAL_W-1:0] value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [dq_pkg::VAL_W-1:0]      value_res,
  output dq_pkg::status_t                      status,
  output logic                                 last
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_res (value_res),
    .status    (status),
    .last      (last),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
